// ===== hdl/fsp_pkg.sv =====
// Package for the framed sensor packet parser.
// Holds frame constants, position codes and the structs passed between modules.
// No dependencies.
package fsp_pkg;

  localparam logic [7:0] SYNC_BYTE = 8'hAA;
  localparam logic [7:0] ADDR_BYTE = 8'h05;
  localparam logic [7:0] MAX_PAYLOAD = 8'd20;

  localparam logic [15:0] LIMIT_RESET = 16'd1000;
  localparam logic [7:0] MSG_ID_RESET = 8'h40;

  // Configuration register indexes.
  localparam logic CFG_LIMIT = 1'b0;
  localparam logic CFG_MSG_ID = 1'b1;

  // Frame positions of the header and the first three payload bytes.
  localparam logic [4:0] POS_SYNC = 5'd0;
  localparam logic [4:0] POS_ANY = 5'd1;
  localparam logic [4:0] POS_ADDR = 5'd2;
  localparam logic [4:0] POS_ID = 5'd3;
  localparam logic [4:0] POS_LEN = 5'd4;
  localparam logic [4:0] POS_DATA0 = 5'd5;
  localparam logic [4:0] POS_DATA1 = 5'd6;
  localparam logic [4:0] POS_DATA2 = 5'd7;

  typedef struct packed {
    logic ok;
    logic [7:0] height;
    logic [15:0] heading;
  } frame_res_t;

  typedef struct packed {
    logic offline;
    logic mode_clear;
  } link_res_t;

endpackage

// ===== hdl/fsp_frame.sv =====
// Frame hunter: header check, running checksum and payload latches.
// Depends on fsp_pkg.
module fsp_frame import fsp_pkg::*; #(
  parameter logic [7:0] PAYLOAD_MAX = MAX_PAYLOAD
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       en,
  input  logic [7:0] rx_byte,
  input  logic [7:0] message_id,
  output frame_res_t res
);

  logic [4:0] pos, pos_next;
  logic [4:0] plen, plen_next;
  logic [7:0] sum, sum_next;
  logic [7:0] lat0, lat1, lat2;
  logic [7:0] lat0_next, lat1_next, lat2_next;
  logic [7:0] height, height_next;
  logic [15:0] heading, heading_next;
  logic ok;
  logic [4:0] check_pos;

  assign check_pos = 5'(plen + POS_DATA0);

  always_comb begin
    pos_next = pos;
    plen_next = plen;
    sum_next = sum;
    height_next = height;
    heading_next = heading;
    ok = 1'b0;

    // Every byte that passes positions 5 to 7 is latched, checksum bytes too.
    lat0_next = (pos == POS_DATA0) ? rx_byte : lat0;
    lat1_next = (pos == POS_DATA1) ? rx_byte : lat1;
    lat2_next = (pos == POS_DATA2) ? rx_byte : lat2;

    priority if (pos == POS_SYNC) begin
      sum_next = 8'd0;
      if (rx_byte == SYNC_BYTE) begin
        sum_next = rx_byte;
        pos_next = POS_ANY;
      end
    end else if (pos == POS_ANY) begin
      sum_next = sum + rx_byte;
      pos_next = pos + 5'd1;
    end else if (pos == POS_ADDR || pos == POS_ID) begin
      if ((pos == POS_ADDR && rx_byte == ADDR_BYTE) ||
          (pos == POS_ID && rx_byte == message_id)) begin
        sum_next = sum + rx_byte;
        pos_next = pos + 5'd1;
      end else begin
        sum_next = 8'd0;
        pos_next = POS_SYNC;
      end
    end else if (pos == POS_LEN) begin
      if (rx_byte < PAYLOAD_MAX) begin
        plen_next = rx_byte[4:0];
        sum_next = sum + rx_byte;
        pos_next = pos + 5'd1;
      end else begin
        sum_next = 8'd0;
        pos_next = POS_SYNC;
      end
    end else if (pos == check_pos) begin
      if (sum == rx_byte) begin
        ok = 1'b1;
        height_next = lat0_next;
        heading_next = {lat1_next, lat2_next};
      end
      sum_next = 8'd0;
      pos_next = POS_SYNC;
    end else begin
      sum_next = sum + rx_byte;
      pos_next = pos + 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= POS_SYNC;
      plen <= 5'd0;
      sum <= 8'd0;
      lat0 <= 8'd0;
      lat1 <= 8'd0;
      lat2 <= 8'd0;
      height <= 8'd0;
      heading <= 16'd0;
    end else if (en) begin
      pos <= pos_next;
      plen <= plen_next;
      sum <= sum_next;
      lat0 <= lat0_next;
      lat1 <= lat1_next;
      lat2 <= lat2_next;
      height <= height_next;
      heading <= heading_next;
    end
  end

  // Result reflects the state after this word, valid only while en is high.
  assign res.ok = en & ok;
  assign res.height = en ? height_next : height;
  assign res.heading = en ? heading_next : heading;

endmodule

// ===== hdl/fsp_link.sv =====
// Link watchdog: silence timer, offline flag and mode_clear pulse.
// Depends on fsp_pkg.
module fsp_link import fsp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        tick,
  input  logic        frame_ok,
  input  logic [7:0]  elapsed_ms,
  input  logic [15:0] limit,
  output link_res_t   res
);

  logic [15:0] timer, timer_next;
  logic offline, offline_next;
  logic mode_clear;
  logic [16:0] timer_sum;

  assign timer_sum = {1'b0, timer} + {9'd0, elapsed_ms};

  always_comb begin
    timer_next = timer;
    offline_next = offline;
    mode_clear = 1'b0;
    if (frame_ok) begin
      timer_next = 16'd0;
      offline_next = 1'b0;
    end else if (tick) begin
      if (timer < limit) begin
        // The add saturates instead of wrapping when the limit is very high.
        timer_next = timer_sum[16] ? 16'hFFFF : timer_sum[15:0];
      end else begin
        offline_next = 1'b1;
        mode_clear = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      timer <= 16'd0;
      offline <= 1'b0;
    end else begin
      timer <= timer_next;
      offline <= offline_next;
    end
  end

  assign res.offline = offline_next;
  assign res.mode_clear = mode_clear;

endmodule

// ===== hdl/framed_sensor_packet_parser.sv =====
// Framed sensor packet parser. Each input word is a received serial byte (op 0) or a
// time tick (op 1), and each word yields exactly one result word in order. A word
// passes an input register and then an output register; one word is taken every
// cycle unless stalled; the single pass of frame and timer logic between the two
// registers sets that rate. The result shows the height and heading of the last
// frame with a good checksum, the offline flag and the mode_clear pulse of a tick.
// Configuration: index 0 is the offline limit in ms, index 1 the expected message id.
module framed_sensor_packet_parser import fsp_pkg::*; #(
  parameter logic [7:0] PAYLOAD_MAX = MAX_PAYLOAD
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic               cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               op,
  input  logic [7:0]         rx_byte,
  input  logic [7:0]         elapsed_ms,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               frame_ok,
  output logic [7:0]         height_cm,
  output logic signed [15:0] heading_offset,
  output logic               offline,
  output logic               mode_clear
);

  logic [15:0] limit;
  logic [7:0] message_id;

  logic s1_valid;
  logic s1_op;
  logic [7:0] s1_byte;
  logic [7:0] s1_elapsed;
  logic advance;
  logic s1_load;
  frame_res_t frame_res;
  link_res_t link_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= LIMIT_RESET;
      message_id <= MSG_ID_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_LIMIT:  limit <= cfg_data;
        CFG_MSG_ID: message_id <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // The input register moves into the output register whenever that one is free.
  assign advance = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !advance;
  assign s1_load = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_load) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_op <= op;
      s1_byte <= rx_byte;
      s1_elapsed <= elapsed_ms;
    end
  end

  fsp_frame #(
    .PAYLOAD_MAX (PAYLOAD_MAX)
  ) u_frame (
    .clk        (clk),
    .rst        (rst),
    .en         (advance && !s1_op),
    .rx_byte    (s1_byte),
    .message_id (message_id),
    .res        (frame_res)
  );

  fsp_link u_link (
    .clk        (clk),
    .rst        (rst),
    .tick       (advance && s1_op),
    .frame_ok   (frame_res.ok),
    .elapsed_ms (s1_elapsed),
    .limit      (limit),
    .res        (link_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      frame_ok <= frame_res.ok;
      height_cm <= frame_res.height;
      heading_offset <= frame_res.heading;
      offline <= link_res.offline;
      mode_clear <= link_res.mode_clear;
    end
  end

endmodule

// ===== hdl/fsp_checker.sv =====
// Port-level checks for the framed sensor packet parser, bound to the top level.
// Depends on framed_sensor_packet_parser's ports only.
module fsp_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic        frame_ok,
  input logic [7:0]  height_cm,
  input logic [15:0] heading_offset,
  input logic        offline,
  input logic        mode_clear
);

  // A stalled result word holds until it is taken.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(height_cm) && $stable(heading_offset)
      && $stable(frame_ok) && $stable(offline) && $stable(mode_clear))
    else $error("stalled result word changed");

  // A good frame always brings the link back online.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_ok |-> !offline)
    else $error("frame_ok with offline set");

  // A timeout pulse is only given while the link is offline.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && mode_clear |-> offline)
    else $error("mode_clear without offline");

  // A word is either a byte or a tick, so both flags cannot come together.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(frame_ok && mode_clear))
    else $error("frame_ok and mode_clear together");

endmodule

bind framed_sensor_packet_parser fsp_checker u_fsp_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .frame_ok       (frame_ok),
  .height_cm      (height_cm),
  .heading_offset (heading_offset),
  .offline        (offline),
  .mode_clear     (mode_clear)
);

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for framed_sensor_packet_parser: directed and random byte/tick
// words, each result checked against a local predictor of the frame hunter and offline timer.
// Depends on fsp_pkg and the framed_sensor_packet_parser module.
module testbench;
  import fsp_pkg::*;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;
  localparam int   DRAIN_PAD = 4;

  typedef struct packed {
    logic               ok;
    logic [7:0]         height;
    logic signed [15:0] heading;
    logic               offline;
    logic               mode_clear;
  } parser_result_t;

  typedef struct packed {
    logic           o;
    logic [7:0]     b;
    logic [7:0]     ms;
    logic           typed;
    parser_result_t res;
  } stim_row_t;

  typedef struct packed {
    logic [15:0] limit;
    logic [7:0]  id;
    logic [7:0]  send_pct;
    logic [7:0]  recv_pct;
    logic [15:0] words;
  } phase_t;

  typedef enum int {FAULT_NONE, FAULT_SUM, FAULT_ADDR, FAULT_ID, FAULT_LEN} frame_fault_t;

  localparam parser_result_t BLANK_RESULT = '0;
  localparam parser_result_t FIRST_FRAME  = {1'b1, 8'h12, 16'h3456, 2'b00};
  localparam parser_result_t HELD_RESULT  = {1'b0, 8'h12, 16'h3456, 2'b00};

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_write = 1'b0;
  logic               cfg_index = CFG_LIMIT;
  logic [15:0]        cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               op = OP_BYTE;
  logic [7:0]         rx_byte = '0;
  logic [7:0]         elapsed_ms = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               frame_ok;
  logic [7:0]         height_cm;
  logic signed [15:0] heading_offset;
  logic               offline;
  logic               mode_clear;

  // Directed words may carry a hand-written result that replaces the prediction.
  logic               item_typed = 1'b0;
  parser_result_t     item_typed_res = '0;

  int send_pct = 34;
  int recv_pct = 86;
  int phase_words = 0;
  int mismatches = 0;
  int results_checked = 0;

  // Predictor state.
  logic [4:0]  hunt_pos;
  logic [4:0]  frame_len;
  logic [7:0]  frame_sum;
  logic [7:0]  field_bytes [3];
  logic [7:0]  held_height;
  logic [15:0] held_heading;
  logic [15:0] silence_ms;
  logic        link_offline;
  logic [15:0] offline_limit;
  logic [7:0]  expected_id;

  parser_result_t expected_results [$];
  stim_row_t      directed_rows [25];
  phase_t         phases [6];

  framed_sensor_packet_parser dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .op            (op),
    .rx_byte       (rx_byte),
    .elapsed_ms    (elapsed_ms),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .frame_ok      (frame_ok),
    .height_cm     (height_cm),
    .heading_offset(heading_offset),
    .offline       (offline),
    .mode_clear    (mode_clear)
  );

  always #6 clk = ~clk;

  initial begin
    #(400000 * 12);
    $display("status: fail");
    $finish;
  end

  task automatic report_mismatch(input string what);
    mismatches++;
    $display("mismatch at result %0d: %s", results_checked, what);
  endtask

  function automatic void grow_frame(input logic [7:0] b);
    frame_sum = frame_sum + b;
    hunt_pos = hunt_pos + 5'd1;
  endfunction

  function automatic void drop_frame();
    hunt_pos = POS_SYNC;
    frame_sum = 8'h00;
  endfunction

  function automatic parser_result_t parse_word(input logic o, input logic [7:0] b,
                                                input logic [7:0] ms);
    parser_result_t r;
    logic [16:0]    grown;
    r = '0;
    if (o == OP_BYTE) begin
      // Positions 5 to 7 are latched on every pass, checksum byte included.
      if (hunt_pos >= POS_DATA0 && hunt_pos <= POS_DATA2)
        field_bytes[2'(hunt_pos - POS_DATA0)] = b;
      if (hunt_pos == POS_SYNC) begin
        frame_sum = 8'h00;
        if (b == SYNC_BYTE) grow_frame(b);
      end else if (hunt_pos == POS_ANY) begin
        grow_frame(b);
      end else if (hunt_pos == POS_ADDR) begin
        if (b == ADDR_BYTE) grow_frame(b);
        else drop_frame();
      end else if (hunt_pos == POS_ID) begin
        if (b == expected_id) grow_frame(b);
        else drop_frame();
      end else if (hunt_pos == POS_LEN) begin
        if (b < MAX_PAYLOAD) begin
          frame_len = b[4:0];
          grow_frame(b);
        end else begin
          drop_frame();
        end
      end else if (hunt_pos == frame_len + POS_DATA0) begin
        if (frame_sum == b) begin
          r.ok = 1'b1;
          held_height = field_bytes[0];
          held_heading = {field_bytes[1], field_bytes[2]};
          silence_ms = 16'h0000;
          link_offline = 1'b0;
        end
        drop_frame();
      end else begin
        grow_frame(b);
      end
    end else if (silence_ms < offline_limit) begin
      grown = {1'b0, silence_ms} + {9'd0, ms};
      silence_ms = (grown > 17'h0FFFF) ? 16'hFFFF : grown[15:0];
    end else begin
      link_offline = 1'b1;
      r.mode_clear = 1'b1;
    end
    r.height = held_height;
    r.heading = held_heading;
    r.offline = link_offline;
    return r;
  endfunction

  always @(posedge clk) begin : monitor
    parser_result_t want;
    parser_result_t got;
    if (rst) begin
      hunt_pos = POS_SYNC;
      frame_len = '0;
      frame_sum = '0;
      field_bytes[0] = '0;
      field_bytes[1] = '0;
      field_bytes[2] = '0;
      held_height = '0;
      held_heading = '0;
      silence_ms = '0;
      link_offline = 1'b0;
      offline_limit = LIMIT_RESET;
      expected_id = MSG_ID_RESET;
      expected_results.delete();
    end else begin
      if (cfg_write) begin
        if (cfg_index == CFG_LIMIT) offline_limit = cfg_data;
        else expected_id = cfg_data[7:0];
      end
      if (in_valid && !in_stall) begin
        want = parse_word(op, rx_byte, elapsed_ms);
        expected_results.push_back(item_typed ? item_typed_res : want);
      end
      if (out_valid && !out_stall) begin
        got = {frame_ok, height_cm, heading_offset, offline, mode_clear};
        if (expected_results.size() == 0) begin
          report_mismatch("result word arrived with nothing expected");
        end else begin
          want = expected_results.pop_front();
          if (got.ok !== want.ok)
            report_mismatch($sformatf("frame_ok got %0d expected %0d", got.ok, want.ok));
          if (got.height !== want.height)
            report_mismatch($sformatf("height_cm got %0d expected %0d",
                                      got.height, want.height));
          if (got.heading !== want.heading)
            report_mismatch($sformatf("heading_offset got %0d expected %0d",
                                      got.heading, want.heading));
          if (got.offline !== want.offline)
            report_mismatch($sformatf("offline got %0d expected %0d",
                                      got.offline, want.offline));
          if (got.mode_clear !== want.mode_clear)
            report_mismatch($sformatf("mode_clear got %0d expected %0d",
                                      got.mode_clear, want.mode_clear));
          results_checked++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(99) < recv_pct);
  end

  task automatic send_word(input logic o, input logic [7:0] b, input logic [7:0] ms,
                           input logic typed, input parser_result_t typed_res);
    while ($urandom_range(99) < send_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    op <= o;
    rx_byte <= b;
    elapsed_ms <= ms;
    item_typed <= typed;
    item_typed_res <= typed_res;
    do @(posedge clk); while (in_stall);
    phase_words++;
  endtask

  task automatic send_tick();
    logic [7:0] ms;
    case ($urandom_range(7))
      0: ms = 8'h00;
      1: ms = 8'hFF;
      default: ms = 8'($urandom);
    endcase
    send_word(OP_TICK, 8'($urandom), ms, 1'b0, BLANK_RESULT);
  endtask

  task automatic send_frame(input frame_fault_t fault);
    logic [7:0] frame [$];
    logic [7:0] sum;
    logic [7:0] flip;
    logic [7:0] len_byte;
    logic [7:0] filler;
    int         len;
    len = $urandom_range(1) ? $urandom_range(3) : $urandom_range(MAX_PAYLOAD - 1);
    flip = 8'($urandom_range(255, 1));
    len_byte = 8'(len);
    if (fault == FAULT_LEN) len_byte = 8'($urandom_range(255, MAX_PAYLOAD));
    filler = 8'($urandom);
    frame.push_back(SYNC_BYTE);
    frame.push_back(filler);
    frame.push_back(fault == FAULT_ADDR ? ADDR_BYTE ^ flip : ADDR_BYTE);
    frame.push_back(fault == FAULT_ID ? expected_id ^ flip : expected_id);
    frame.push_back(len_byte);
    repeat (len) begin
      filler = 8'($urandom);
      frame.push_back(filler);
    end
    sum = 8'h00;
    foreach (frame[i]) sum = sum + frame[i];
    frame.push_back(fault == FAULT_SUM ? sum ^ flip : sum);
    // Ticks may land anywhere inside a frame without disturbing the hunt.
    foreach (frame[i]) begin
      if ($urandom_range(9) == 0) send_tick();
      send_word(OP_BYTE, frame[i], 8'($urandom), 1'b0, BLANK_RESULT);
    end
  endtask

  // Hold the sender off until every expected word has come back and the pipe is empty.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_results.size() != 0);
    repeat (DRAIN_PAD) @(posedge clk);
  endtask

  initial begin : stimulus
    int pick;
    directed_rows = '{
      {OP_TICK, 8'h00,       8'h00, 1'b1, BLANK_RESULT},
      {OP_BYTE, SYNC_BYTE,   8'h00, 1'b1, BLANK_RESULT},
      {OP_BYTE, 8'h00,       8'h00, 1'b1, BLANK_RESULT},
      {OP_BYTE, ADDR_BYTE,   8'h00, 1'b1, BLANK_RESULT},
      {OP_BYTE, MSG_ID_RESET, 8'h00, 1'b1, BLANK_RESULT},
      {OP_BYTE, 8'h03,       8'h00, 1'b1, BLANK_RESULT},
      {OP_BYTE, 8'h12,       8'h00, 1'b1, BLANK_RESULT},
      {OP_BYTE, 8'h34,       8'h00, 1'b1, BLANK_RESULT},
      {OP_BYTE, 8'h56,       8'h00, 1'b1, BLANK_RESULT},
      {OP_BYTE, 8'h8E,       8'h00, 1'b1, FIRST_FRAME},
      // Address mismatch drops the hunt.
      {OP_BYTE, SYNC_BYTE,   8'h00, 1'b1, HELD_RESULT},
      {OP_BYTE, 8'hFF,       8'h00, 1'b1, HELD_RESULT},
      {OP_BYTE, 8'h06,       8'h00, 1'b1, HELD_RESULT},
      // Length at the payload limit is rejected.
      {OP_BYTE, SYNC_BYTE,   8'h00, 1'b1, HELD_RESULT},
      {OP_BYTE, 8'h01,       8'h00, 1'b1, HELD_RESULT},
      {OP_BYTE, ADDR_BYTE,   8'h00, 1'b1, HELD_RESULT},
      {OP_BYTE, MSG_ID_RESET, 8'h00, 1'b1, HELD_RESULT},
      {OP_BYTE, MAX_PAYLOAD, 8'h00, 1'b1, HELD_RESULT},
      // Empty payload: the checksum byte itself becomes the height, heading stays stale.
      {OP_BYTE, SYNC_BYTE,   8'h00, 1'b0, BLANK_RESULT},
      {OP_BYTE, 8'h00,       8'h00, 1'b0, BLANK_RESULT},
      {OP_BYTE, ADDR_BYTE,   8'h00, 1'b0, BLANK_RESULT},
      {OP_BYTE, MSG_ID_RESET, 8'h00, 1'b0, BLANK_RESULT},
      {OP_BYTE, 8'h00,       8'h00, 1'b0, BLANK_RESULT},
      {OP_BYTE, 8'hEF,       8'h00, 1'b0, BLANK_RESULT},
      {OP_TICK, 8'hFF,       8'hFF, 1'b0, BLANK_RESULT}
    };
    phases = '{
      {16'd1,       8'h00,        8'd34, 8'd86, 16'd150},
      {16'd65280,   8'hFF,        8'd34, 8'd86, 16'd360},
      {16'd300,     8'h40,        8'd86, 8'd34, 16'd150},
      {16'hFFFF,    8'h7E,        8'd86, 8'd34, 16'd360},
      {16'd0,       8'hAA,        8'd0,  8'd0,  16'd150},
      {LIMIT_RESET, MSG_ID_RESET, 8'd0,  8'd0,  16'd150}
    };

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      send_word(directed_rows[i].o, directed_rows[i].b, directed_rows[i].ms,
                directed_rows[i].typed, directed_rows[i].res);

    foreach (phases[p]) begin
      drain_results();
      cfg_write <= 1'b1;
      cfg_index <= CFG_LIMIT;
      cfg_data <= phases[p].limit;
      @(posedge clk);
      cfg_index <= CFG_MSG_ID;
      cfg_data <= {8'h00, phases[p].id};
      @(posedge clk);
      cfg_write <= 1'b0;
      // Wait for the predictor to take the new id before frames are built.
      @(posedge clk);
      send_pct = phases[p].send_pct;
      recv_pct = phases[p].recv_pct;
      phase_words = 0;

      // Large limits need a long silence to time out or to saturate the timer.
      if (phases[p].limit >= 16'd65280)
        repeat (300) send_word(OP_TICK, 8'($urandom), 8'($urandom_range(255, 200)), 1'b0,
                               BLANK_RESULT);

      while (phase_words < phases[p].words) begin
        pick = $urandom_range(99);
        if (pick < 55) send_frame(FAULT_NONE);
        else if (pick < 72) send_frame(frame_fault_t'($urandom_range(FAULT_LEN, FAULT_SUM)));
        else if (pick < 87) send_tick();
        else if (pick < 95) send_word(OP_BYTE, 8'($urandom), 8'($urandom), 1'b0, BLANK_RESULT);
        else repeat ($urandom_range(40, 10)) send_tick();
      end
    end

    drain_results();
    if (mismatches == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/fsp_pkg.sv
hdl/fsp_frame.sv
hdl/fsp_link.sv
hdl/framed_sensor_packet_parser.sv
hdl/fsp_checker.sv
tb/sv/testbench.sv
